[rtl/cmh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmh_pkg: shared types and constants of the minimizer hash stream unit
// Link record passed along the window cell chain, controller states and
// configuration register indexes with their reset values.
// ----------------------------------------------------------------------------
package cmh_pkg;

   localparam int HASH_W = 64;

   typedef logic [HASH_W-1:0] hash_type;

   // What one window cell hands to its older neighbor: the hash it holds and
   // the minimum of that hash and every newer hash in the window.
   typedef struct packed {
      hash_type hash;
      hash_type pmin;
   } link_type;

   typedef enum logic [2:0] {
      S_SETUP,
      S_IDLE,
      S_HASH,
      S_CANON,
      S_UPDATE
   } state_type;

   localparam logic [1:0] REG_KMER_LEN   = 2'd0;
   localparam logic [1:0] REG_WINDOW_LEN = 2'd1;
   localparam logic [1:0] REG_SHAPE_MASK = 2'd2;
   localparam logic [1:0] REG_HASH_SEED  = 2'd3;

   localparam logic [5:0]  KMER_LEN_RESET   = 6'd15;
   localparam logic [6:0]  WINDOW_LEN_RESET = 7'd24;
   localparam logic [31:0] SHAPE_MASK_RESET = 32'h0000_7FFF;
   localparam hash_type    HASH_SEED_RESET  = '0;

endpackage

[rtl/canonical_minimizer_hash_stream_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_minimizer_hash_stream_unit: canonical k-mer window minimizer
// Streams 2-bit bases, hashes shaped forward and reverse-complement k-mers,
// keeps the window of canonical hashes in a cell chain and reports minimizers.
// ----------------------------------------------------------------------------
// A base that does not yet complete a k-mer is taken at once. A base that
// completes a k-mer passes four steps before the next is taken: k-mer update,
// shape compaction, the canonical compare with the window tail read, and the
// cell chain shift with the minimum update; the fourth waits, if it emits,
// while an earlier result is stalled in the output register. After reset and
// after every register write the shape routing table is rebuilt, one k-mer
// position per cycle, so no base is taken in the cycle of a write nor until
// the table is complete. A register write ends the read in progress. At most
// one item leaves per base, with at_read_end set on the base marked last.
module canonical_minimizer_hash_stream_unit #(
   parameter int MAX_WINDOW_KMERS = 64,
   parameter int MAX_KMER_LEN     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_base,
   input  logic        req_last_base,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_minimizer_hash,
   output logic        rsp_at_read_end,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int KW2 = 2 * MAX_KMER_LEN;
   localparam int NW  = $clog2(MAX_WINDOW_KMERS + 1);
   localparam int DW  = (NW > 8) ? NW : 8;

   // configuration
   logic [5:0]        kmer_len_ff;
   logic [6:0]        window_len_ff;
   logic [31:0]       shape_mask_ff;
   cmh_pkg::hash_type hash_seed_ff;
   logic [5:0]        k_eff, k_ff;
   logic [NW-1:0]     nk_eff, nk_ff;
   logic [DW-1:0]     span;

   // per-read state
   cmh_pkg::state_type state_ff, state_in;
   logic [KW2-1:0]     fwd_ff, fwd_in, fwd_shift;
   logic [KW2-1:0]     rev_ff, rev_in, rev_shift, rev_down;
   logic [5:0]         bc_ff, bc_in;
   logic [NW-1:0]      kc_ff, kc_in, kc_plus;
   cmh_pkg::hash_type  cur_min_ff, cur_min_in;
   logic               last_ff, last_in;
   cmh_pkg::hash_type  c_ff, c_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   cmh_pkg::hash_type  rsp_hash_ff, rsp_hash_in;
   logic               rsp_end_ff, rsp_end_in;

   // control
   logic               accept, finish, shape_restart, clear_read;
   logic               kmer_ok, steady, rescan, lt, emit, out_free;
   cmh_pkg::hash_type  rescan_min, min_next;
   logic               shape_busy;
   cmh_pkg::hash_type  fwd_hash, rev_hash;
   cmh_pkg::link_type  tap;

   // Effective k-mer length and k-mer count of a window.
   always_comb begin
      if (kmer_len_ff == 6'd0) begin
         k_eff = 6'd1;
      end else if (kmer_len_ff > 6'(MAX_KMER_LEN)) begin
         k_eff = 6'(MAX_KMER_LEN);
      end else begin
         k_eff = kmer_len_ff;
      end
      span = DW'(window_len_ff) - DW'(k_eff) + DW'(1);
      if (DW'(window_len_ff) < DW'(k_eff)) begin
         nk_eff = NW'(1);
      end else if (span > DW'(MAX_WINDOW_KMERS)) begin
         nk_eff = NW'(MAX_WINDOW_KMERS);
      end else begin
         nk_eff = NW'(span);
      end
   end

   always_ff @(posedge clock) begin
      k_ff  <= k_eff;
      nk_ff <= nk_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff   <= cmh_pkg::KMER_LEN_RESET;
         window_len_ff <= cmh_pkg::WINDOW_LEN_RESET;
         shape_mask_ff <= cmh_pkg::SHAPE_MASK_RESET;
         hash_seed_ff  <= cmh_pkg::HASH_SEED_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            cmh_pkg::REG_KMER_LEN:   kmer_len_ff   <= csr_data[5:0];
            cmh_pkg::REG_WINDOW_LEN: window_len_ff <= csr_data[6:0];
            cmh_pkg::REG_SHAPE_MASK: shape_mask_ff <= csr_data[31:0];
            cmh_pkg::REG_HASH_SEED:  hash_seed_ff  <= csr_data;
         endcase
      end
   end

   // K-mer shift: forward takes the base at the low end, reverse complement
   // takes the complemented base at group k-1.
   always_comb begin
      fwd_shift = KW2'({fwd_ff, req_base});
      rev_down  = rev_ff >> 2;
      rev_shift = rev_down;
      for (int g = 0; g < MAX_KMER_LEN; g++) begin
         if (!(6'(g) < k_ff)) begin
            fwd_shift[2*g +: 2] = 2'b00;
         end
         if (6'(g) == k_ff - 6'd1) begin
            rev_shift[2*g +: 2] = ~req_base;
         end
      end
      kmer_ok = (7'(bc_ff) + 7'd1) >= 7'(k_ff);
   end

   // Canonical choice and window update decisions, the latter used in an item's last step.
   always_comb begin
      c_in       = (fwd_hash <= rev_hash) ? fwd_hash : rev_hash;
      steady     = (kc_ff == nk_ff);
      kc_plus    = kc_ff + NW'(1);
      rescan     = (tap.hash == cur_min_ff);
      lt         = (c_ff < cur_min_ff);
      rescan_min = (c_ff <= tap.pmin) ? c_ff : tap.pmin;
      if (steady && rescan) begin
         min_next = rescan_min;
      end else if (lt) begin
         min_next = c_ff;
      end else begin
         min_next = cur_min_ff;
      end
      if (steady) begin
         emit = rescan || lt;
      end else begin
         emit = (kc_plus == nk_ff) || last_ff;
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmh_pkg::S_SETUP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      accept        = 1'b0;
      finish        = 1'b0;
      shape_restart = csr_write;
      unique case (state_ff)
         cmh_pkg::S_SETUP: begin
            if (!shape_busy) begin
               state_in = cmh_pkg::S_IDLE;
            end
         end
         cmh_pkg::S_IDLE: begin
            req_stall = csr_write;
            accept    = req_valid && !csr_write;
            if (accept && kmer_ok) begin
               state_in = cmh_pkg::S_HASH;
            end
         end
         cmh_pkg::S_HASH: begin
            state_in = cmh_pkg::S_CANON;
         end
         cmh_pkg::S_CANON: begin
            state_in = cmh_pkg::S_UPDATE;
         end
         cmh_pkg::S_UPDATE: begin
            finish = !emit || out_free;
            if (finish) begin
               state_in = cmh_pkg::S_IDLE;
            end
         end
      endcase
      if (csr_write) begin
         state_in = cmh_pkg::S_SETUP;
      end
      clear_read = csr_write || (accept && !kmer_ok && req_last_base) || (finish && last_ff);
   end

   always_comb begin
      fwd_in     = fwd_ff;
      rev_in     = rev_ff;
      bc_in      = bc_ff;
      kc_in      = kc_ff;
      cur_min_in = cur_min_ff;
      last_in    = last_ff;
      if (accept) begin
         fwd_in  = fwd_shift;
         rev_in  = rev_shift;
         bc_in   = kmer_ok ? k_ff : bc_ff + 6'd1;
         last_in = req_last_base;
      end
      if (finish) begin
         kc_in      = steady ? kc_ff : kc_plus;
         cur_min_in = min_next;
      end
      if (clear_read) begin
         fwd_in     = '0;
         rev_in     = '0;
         bc_in      = '0;
         kc_in      = '0;
         cur_min_in = '1;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      rsp_end_in   = rsp_end_ff;
      if (finish && emit) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = min_next;
         rsp_end_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= '0;
         rev_ff       <= '0;
         bc_ff        <= '0;
         kc_ff        <= '0;
         cur_min_ff   <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_ff       <= fwd_in;
         rev_ff       <= rev_in;
         bc_ff        <= bc_in;
         kc_ff        <= kc_in;
         cur_min_ff   <= cur_min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      c_ff        <= c_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_end_ff  <= rsp_end_in;
   end

   cmh_shape_hash #(
      .MAX_KMER_LEN (MAX_KMER_LEN)
   ) u_shape (
      .clock      (clock),
      .reset      (reset),
      .restart    (shape_restart),
      .kmer_len   (k_eff),
      .shape_mask (shape_mask_ff),
      .hash_seed  (hash_seed_ff),
      .fwd_kmer   (fwd_ff),
      .rev_kmer   (rev_ff),
      .busy       (shape_busy),
      .fwd_hash   (fwd_hash),
      .rev_hash   (rev_hash)
   );

   cmh_window_chain #(
      .MAX_WINDOW_KMERS (MAX_WINDOW_KMERS)
   ) u_window (
      .clock    (clock),
      .shift    (finish),
      .new_hash (c_ff),
      .nk       (nk_ff),
      .tap      (tap)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_minimizer_hash = rsp_hash_ff;
   assign rsp_at_read_end    = rsp_end_ff;

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == cmh_pkg::S_UPDATE)
      else $error("result appeared outside the window update step");

   a_kmer_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == cmh_pkg::S_IDLE |-> kc_ff <= nk_ff)
      else $error("k-mer count exceeds the window size");

   a_routing_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != cmh_pkg::S_SETUP |-> !shape_busy)
      else $error("shape routing table still being built outside setup");

endmodule

[rtl/cmh_shape_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmh_shape_hash: shaped k-mer hash compaction
// Builds a routing table from the k-mer length and shape mask in a setup
// sweep of one k-mer position per cycle, then packs the selected bases of the
// forward and reverse-complement k-mers and XORs in the seed every cycle.
// ----------------------------------------------------------------------------
module cmh_shape_hash #(
   parameter int MAX_KMER_LEN = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic [5:0]                  kmer_len,
   input  logic [31:0]                 shape_mask,
   input  cmh_pkg::hash_type           hash_seed,
   input  logic [2*MAX_KMER_LEN-1:0]   fwd_kmer,
   input  logic [2*MAX_KMER_LEN-1:0]   rev_kmer,
   output logic                        busy,
   output cmh_pkg::hash_type           fwd_hash,
   output cmh_pkg::hash_type           rev_hash
);

   localparam int KW2 = 2 * MAX_KMER_LEN;
   localparam int GW  = (MAX_KMER_LEN > 1) ? $clog2(MAX_KMER_LEN) : 1;
   localparam int CW  = $clog2(MAX_KMER_LEN + 1);

   logic                    busy_ff, busy_in;
   logic [GW-1:0]           grp_ff, grp_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [MAX_KMER_LEN-1:0] route_ff [MAX_KMER_LEN];
   logic [MAX_KMER_LEN-1:0] route_in [MAX_KMER_LEN];
   cmh_pkg::hash_type       fwd_hash_ff, fwd_hash_in;
   cmh_pkg::hash_type       rev_hash_ff, rev_hash_in;

   logic [5:0]              pos;
   logic                    in_shape;
   logic [MAX_KMER_LEN-1:0] row;
   logic [KW2-1:0]          fwd_pack, rev_pack;

   // Group g counts from the newest base. Its slot in the packed hash is the
   // number of selected groups newer than it, so the oldest selected base
   // lands in the most significant slot.
   always_comb begin
      pos      = kmer_len - 6'd1 - 6'(grp_ff);
      in_shape = (6'(grp_ff) < kmer_len) && shape_mask[pos[4:0]];
      for (int s = 0; s < MAX_KMER_LEN; s++) begin
         row[s] = in_shape && (cnt_ff == CW'(s));
      end
   end

   always_comb begin
      busy_in = busy_ff;
      grp_in  = grp_ff;
      cnt_in  = cnt_ff;
      for (int i = 0; i < MAX_KMER_LEN; i++) begin
         route_in[i] = route_ff[i];
      end
      if (restart) begin
         busy_in = 1'b1;
         grp_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < MAX_KMER_LEN - 1; i++) begin
            route_in[i] = route_ff[i + 1];
         end
         route_in[MAX_KMER_LEN-1] = row;
         cnt_in = cnt_ff + CW'(in_shape);
         if (grp_ff == GW'(MAX_KMER_LEN - 1)) begin
            busy_in = 1'b0;
         end else begin
            grp_in = grp_ff + GW'(1);
         end
      end
   end

   always_comb begin
      fwd_pack = '0;
      rev_pack = '0;
      for (int s = 0; s < MAX_KMER_LEN; s++) begin
         for (int g = 0; g < MAX_KMER_LEN; g++) begin
            if (route_ff[g][s]) begin
               fwd_pack[2*s +: 2] = fwd_pack[2*s +: 2] | fwd_kmer[2*g +: 2];
               rev_pack[2*s +: 2] = rev_pack[2*s +: 2] | rev_kmer[2*g +: 2];
            end
         end
      end
      fwd_hash_in = cmh_pkg::HASH_W'(fwd_pack) ^ hash_seed;
      rev_hash_in = cmh_pkg::HASH_W'(rev_pack) ^ hash_seed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         grp_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         grp_ff  <= grp_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_KMER_LEN; i++) begin
         route_ff[i] <= route_in[i];
      end
      fwd_hash_ff <= fwd_hash_in;
      rev_hash_ff <= rev_hash_in;
   end

   assign busy     = busy_ff;
   assign fwd_hash = fwd_hash_ff;
   assign rev_hash = rev_hash_ff;

endmodule

[rtl/cmh_window_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmh_window_cell: one slot of the minimizer window
// Holds one canonical hash and the running minimum from the newest slot up to
// this one; a shift loads the neighbor's hash and the min of its pmin and new_hash.
// ----------------------------------------------------------------------------
module cmh_window_cell (
   input  logic               clock,
   input  logic               shift,
   input  cmh_pkg::hash_type  new_hash,
   input  cmh_pkg::link_type  prev_link,
   output cmh_pkg::link_type  cell_link
);

   cmh_pkg::link_type cell_ff, cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (shift) begin
         cell_in.hash = prev_link.hash;
         cell_in.pmin = (new_hash < prev_link.pmin) ? new_hash : prev_link.pmin;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_link = cell_ff;

endmodule

[rtl/cmh_window_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmh_window_chain: shift chain of window cells
// The newest hash enters cell 0 and every cell hands its contents to the next
// one. The tail tap reports the hash about to leave the window and the
// minimum of all hashes that stay.
// ----------------------------------------------------------------------------
module cmh_window_chain #(
   parameter int MAX_WINDOW_KMERS = 64
) (
   input  logic                                   clock,
   input  logic                                   shift,
   input  cmh_pkg::hash_type                      new_hash,
   input  logic [$clog2(MAX_WINDOW_KMERS+1)-1:0]  nk,
   output cmh_pkg::link_type                      tap
);

   localparam int NW = $clog2(MAX_WINDOW_KMERS + 1);

   cmh_pkg::link_type link [MAX_WINDOW_KMERS+1];
   cmh_pkg::link_type tap_ff, tap_in;
   logic [NW-1:0]     tail;

   assign link[0] = '{hash: new_hash, pmin: '1};

   for (genvar j = 0; j < MAX_WINDOW_KMERS; j++) begin : g_cell
      cmh_window_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .new_hash  (new_hash),
         .prev_link (link[j]),
         .cell_link (link[j+1])
      );
   end

   // The minimum over the cells newer than the tail is the running minimum
   // that the tail cell receives; ahead of cell 0 it is all ones.
   always_comb begin
      tail   = nk - NW'(1);
      tap_in = '0;
      for (int j = 0; j < MAX_WINDOW_KMERS; j++) begin
         if (NW'(j) == tail) begin
            tap_in = tap_in | cmh_pkg::link_type'{hash: link[j+1].hash, pmin: link[j].pmin};
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign tap = tap_ff;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the canonical minimizer hash stream unit
// Streams DNA reads through the unit under a series of k-mer, window, shape
// and seed settings. A short directed table covers the corner settings, then
// random reads follow. Every result item is checked against the listed hash or
// an in-bench model of the window minimizer, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned WINDOW_SLOTS = 64;
   localparam int unsigned KMER_MAX     = 32;
   localparam int unsigned RANDOM_BASES = 1050;

   typedef struct {
      cmh_pkg::hash_type hash;
      logic              at_end;
   } minimizer_type;

   typedef struct {
      bit                is_write;
      logic [1:0]        index;
      logic [63:0]       value;
      logic [1:0]        base;
      logic              last;
      bit                typed;
      cmh_pkg::hash_type hash;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_base;
   logic        req_last_base;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_minimizer_hash;
   logic        rsp_at_read_end;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   canonical_minimizer_hash_stream_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_base           (req_base),
      .req_last_base      (req_last_base),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_minimizer_hash (rsp_minimizer_hash),
      .rsp_at_read_end    (rsp_at_read_end),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Shadow registers and per-read state of the minimizer model.
   logic [5:0]        cfg_k;
   logic [6:0]        cfg_w;
   logic [31:0]       cfg_mask;
   cmh_pkg::hash_type cfg_seed;
   logic [63:0]       fwd_kmer;
   logic [63:0]       rc_kmer;
   cmh_pkg::hash_type win_hash [0:WINDOW_SLOTS-1];
   int unsigned       head;
   int unsigned       seen;
   cmh_pkg::hash_type cur_min;

   minimizer_type     pending_minimizers [$];
   plan_row_type      plan [$];
   int unsigned       faults;
   int unsigned       sent;
   bit                calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void clear_read();
      fwd_kmer = '0;
      rc_kmer  = '0;
      head     = 0;
      seen     = 0;
      cur_min  = '1;
   endfunction

   function automatic void apply_config(input logic [1:0] index,
                                        input logic [63:0] value);
      case (index)
         cmh_pkg::REG_KMER_LEN:   cfg_k    = value[5:0];
         cmh_pkg::REG_WINDOW_LEN: cfg_w    = value[6:0];
         cmh_pkg::REG_SHAPE_MASK: cfg_mask = value[31:0];
         cmh_pkg::REG_HASH_SEED:  cfg_seed = value;
         default: ;
      endcase
      clear_read();
   endfunction

   function automatic int unsigned eff_kmer();
      if (cfg_k == 0) return 1;
      if (cfg_k > KMER_MAX) return KMER_MAX;
      return 32'(cfg_k);
   endfunction

   function automatic int unsigned eff_window(input int unsigned k);
      int unsigned w;
      w = (cfg_w < k) ? k : 32'(cfg_w);
      if (w - k + 1 > WINDOW_SLOTS) w = k + WINDOW_SLOTS - 1;
      return w;
   endfunction

   // Packs the selected k-mer positions, oldest position most significant.
   function automatic cmh_pkg::hash_type shaped(input logic [63:0] kmer_bits,
                                                input int unsigned k);
      cmh_pkg::hash_type h;
      h = '0;
      for (int unsigned p = 0; p < k; p++)
         if (cfg_mask[p]) h = {h[61:0], kmer_bits[2*(k-1-p) +: 2]};
      return h;
   endfunction

   function automatic bit next_minimizer(input logic [1:0] b, input logic last,
                                         output cmh_pkg::hash_type min_hash);
      int unsigned       k, w, nk, n;
      logic [63:0]       kmask;
      cmh_pkg::hash_type fh, rh, canon, rescan;
      bit                fired;
      k     = eff_kmer();
      w     = eff_window(k);
      nk    = w - k + 1;
      kmask = (k >= KMER_MAX) ? '1 : ((64'd1 << (2*k)) - 64'd1);
      fired = 1'b0;
      fwd_kmer = ((fwd_kmer << 2) | 64'(b)) & kmask;
      rc_kmer  = ((rc_kmer >> 2) | (64'(2'd3 - b) << (2*(k-1)))) & kmask;
      n = (seen + 1 > w) ? w : seen + 1;
      if (n >= k) begin
         fh    = shaped(fwd_kmer, k) ^ cfg_seed;
         rh    = shaped(rc_kmer, k) ^ cfg_seed;
         canon = (fh <= rh) ? fh : rh;
         if (head >= nk) head = 0;
         if (seen >= w) begin
            // The oldest hash leaves; if it held the minimum, rescan the rest.
            if (win_hash[head] == cur_min) begin
               rescan = '1;
               for (int unsigned j = 0; j < nk; j++)
                  if (j != head && win_hash[j] < rescan) rescan = win_hash[j];
               cur_min = rescan;
               fired   = 1'b1;
            end
            if (canon < cur_min) begin
               cur_min = canon;
               fired   = 1'b1;
            end
         end else begin
            if (canon < cur_min) cur_min = canon;
            if (n == w || last) fired = 1'b1;
         end
         win_hash[head] = canon;
         head = (head + 1 >= nk) ? 0 : head + 1;
      end
      seen     = n;
      min_hash = cur_min;
      if (last) clear_read();
      return fired;
   endfunction

   function automatic plan_row_type write_row(input logic [1:0] index,
                                              input logic [63:0] value);
      plan_row_type r;
      r = '{1'b1, index, value, 2'd0, 1'b0, 1'b0, '0};
      return r;
   endfunction

   function automatic plan_row_type base_row(input logic [1:0] b, input logic last);
      plan_row_type r;
      r = '{1'b0, cmh_pkg::REG_KMER_LEN, '0, b, last, 1'b0, '0};
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [1:0] b, input logic last,
                                              input cmh_pkg::hash_type hash);
      plan_row_type r;
      r = '{1'b0, cmh_pkg::REG_KMER_LEN, '0, b, last, 1'b1, hash};
      return r;
   endfunction

   function automatic void add_row(input plan_row_type r);
      plan = {plan, r};
   endfunction

   // Waits until every expected item has come out and the pipeline has drained.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_minimizers.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      apply_config(index, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_base(input logic [1:0] b, input logic last, input bit typed,
                            input cmh_pkg::hash_type hash);
      int unsigned   gap;
      minimizer_type m;
      bit            fired;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_base      <= b;
      req_last_base <= last;
      do @(posedge clock); while (req_stall);
      fired    = next_minimizer(b, last, m.hash);
      m.at_end = last;
      if (typed) begin
         m.hash = hash;
         pending_minimizers = {pending_minimizers, m};
      end else if (fired) begin
         pending_minimizers = {pending_minimizers, m};
      end
      sent++;
   endtask

   initial begin : result_stall
      int unsigned hold;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 11);
         rsp_stall <= (hold != 0);
         if (hold != 0) begin
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : check_results
      minimizer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_minimizers.size() == 0) begin
            $error("unexpected item: minimizer_hash %h", rsp_minimizer_hash);
            faults++;
         end else begin
            want = pending_minimizers[0];
            pending_minimizers.delete(0);
            if (rsp_minimizer_hash !== want.hash) begin
               $error("minimizer_hash: expected %h, got %h", want.hash, rsp_minimizer_hash);
               faults++;
            end
            if (rsp_at_read_end !== want.at_end) begin
               $error("at_read_end: expected %b, got %b", want.at_end, rsp_at_read_end);
               faults++;
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type      row;
      logic [5:0]        kraw;
      logic [6:0]        wraw;
      logic [31:0]       mask;
      cmh_pkg::hash_type seed;
      int unsigned       k, w, len, budget, done, target;

      faults        = 0;
      sent          = 0;
      calm          = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_base      <= 2'd0;
      req_last_base <= 1'b0;
      csr_write     <= 1'b0;
      csr_index     <= cmh_pkg::REG_KMER_LEN;
      csr_data      <= '0;
      cfg_k    = cmh_pkg::KMER_LEN_RESET;
      cfg_w    = cmh_pkg::WINDOW_LEN_RESET;
      cfg_mask = cmh_pkg::SHAPE_MASK_RESET;
      cfg_seed = cmh_pkg::HASH_SEED_RESET;
      foreach (win_hash[i]) win_hash[i] = '0;
      clear_read();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a read shorter than the k-mer gives nothing.
      add_row(base_row(2'd0, 1'b0));
      add_row(base_row(2'd3, 1'b1));
      // A k-mer length of zero acts as one; a one k-mer window emits every base.
      add_row(write_row(cmh_pkg::REG_KMER_LEN, 64'd0));
      add_row(write_row(cmh_pkg::REG_WINDOW_LEN, 64'd1));
      add_row(write_row(cmh_pkg::REG_SHAPE_MASK, 64'd1));
      add_row(write_row(cmh_pkg::REG_HASH_SEED, 64'd0));
      add_row(known_row(2'd0, 1'b0, 64'd0));
      add_row(known_row(2'd1, 1'b0, 64'd1));
      add_row(known_row(2'd2, 1'b0, 64'd1));
      add_row(known_row(2'd3, 1'b1, 64'd0));
      add_row(write_row(cmh_pkg::REG_HASH_SEED, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(known_row(2'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFC));
      // An empty shape hashes to the seed alone.
      add_row(write_row(cmh_pkg::REG_SHAPE_MASK, 64'd0));
      add_row(known_row(2'd2, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(known_row(2'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
      // Oversized k-mer and window are clamped.
      add_row(write_row(cmh_pkg::REG_KMER_LEN, 64'd63));
      add_row(write_row(cmh_pkg::REG_WINDOW_LEN, 64'd127));
      add_row(write_row(cmh_pkg::REG_SHAPE_MASK, 64'hFFFF_FFFF));
      add_row(write_row(cmh_pkg::REG_HASH_SEED, 64'd0));
      add_row(base_row(2'd1, 1'b0));
      add_row(base_row(2'd2, 1'b1));
      // Window below the k-mer length, sparse shape with bits above the k-mer.
      add_row(write_row(cmh_pkg::REG_KMER_LEN, 64'd3));
      add_row(write_row(cmh_pkg::REG_WINDOW_LEN, 64'd2));
      add_row(write_row(cmh_pkg::REG_SHAPE_MASK, 64'h8000_0005));
      add_row(write_row(cmh_pkg::REG_HASH_SEED, 64'h0123_4567_89AB_CDEF));
      add_row(base_row(2'd3, 1'b0));
      add_row(base_row(2'd0, 1'b0));
      add_row(base_row(2'd2, 1'b0));
      add_row(base_row(2'd1, 1'b0));
      add_row(base_row(2'd3, 1'b1));
      // A read shorter than the window, then one that reaches steady state.
      add_row(write_row(cmh_pkg::REG_KMER_LEN, 64'd2));
      add_row(write_row(cmh_pkg::REG_WINDOW_LEN, 64'd6));
      add_row(write_row(cmh_pkg::REG_SHAPE_MASK, 64'd3));
      add_row(write_row(cmh_pkg::REG_HASH_SEED, 64'd0));
      add_row(base_row(2'd2, 1'b0));
      add_row(base_row(2'd1, 1'b0));
      add_row(base_row(2'd0, 1'b1));
      add_row(base_row(2'd3, 1'b0));
      add_row(base_row(2'd3, 1'b0));
      add_row(base_row(2'd0, 1'b0));
      add_row(base_row(2'd1, 1'b0));
      add_row(base_row(2'd2, 1'b0));
      add_row(base_row(2'd0, 1'b0));
      add_row(base_row(2'd3, 1'b1));

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_write) begin
            settle();
            write_reg(row.index, row.value);
         end else begin
            send_base(row.base, row.last, row.typed, row.hash);
         end
      end

      target = sent + RANDOM_BASES;
      while (sent < target) begin
         settle();
         case ($urandom_range(0, 7))
            0: begin
               kraw = 6'd32;
               wraw = 7'd127;
            end
            1: begin
               kraw = 6'($urandom_range(0, 63));
               wraw = 7'($urandom_range(0, 127));
            end
            2: begin
               kraw = 6'd1;
               wraw = 7'd1;
            end
            default: begin
               kraw = 6'($urandom_range(1, 6));
               wraw = 7'($urandom_range(0, kraw + 10));
            end
         endcase
         case ($urandom_range(0, 5))
            0: mask = '1;
            1: mask = '0;
            2: mask = $urandom & 32'h0000_00FF;
            default: mask = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0: seed = '0;
            1: seed = '1;
            default: seed = {$urandom, $urandom};
         endcase
         write_reg(cmh_pkg::REG_KMER_LEN, 64'(kraw));
         write_reg(cmh_pkg::REG_WINDOW_LEN, 64'(wraw));
         write_reg(cmh_pkg::REG_SHAPE_MASK, 64'(mask));
         write_reg(cmh_pkg::REG_HASH_SEED, seed);
         calm   = ($urandom_range(0, 4) == 0);
         k      = eff_kmer();
         w      = eff_window(k);
         budget = (w > 40) ? $urandom_range(100, 250) : $urandom_range(30, 90);
         done   = 0;
         // Mostly full reads; some end before a k-mer or a window completes,
         // and the last one is often cut short by the next register write.
         while (done < budget) begin
            case ($urandom_range(0, 9))
               0: len = (k > 1) ? $urandom_range(1, k - 1) : 1;
               1: len = $urandom_range(k, w);
               default: len = w + $urandom_range(0, 3 * (w - k + 1) + 4);
            endcase
            for (int unsigned i = 0; i < len && done < budget; i++) begin
               send_base(2'($urandom_range(0, 3)), i == len - 1, 1'b0, '0);
               done++;
            end
         end
      end

      req_valid <= 1'b0;
      calm = 1'b0;
      while (pending_minimizers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
